// File: design/kab_pkg.sv
`timescale 1ns / 1ps

package kab_pkg;

  localparam int NodeCountDef = 256;
  localparam int LevelsDef    = 8;
  localparam int NodeWidth    = 8;
  localparam int StepsWidth   = 8;

  typedef enum logic [1:0] {
    OpSetParent = 2'd0,
    OpBuild     = 2'd1,
    OpQuery     = 2'd2
  } op_e;

  // One table entry: the ancestor node and whether it exists.
  typedef struct packed {
    logic                 valid;
    logic [NodeWidth-1:0] node;
  } entry_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [NodeWidth-1:0]  node;
    logic [NodeWidth-1:0]  parent_node;
    logic                  parent_exists;
    logic [StepsWidth-1:0] steps_up;
  } cmd_t;

  typedef struct packed {
    logic [NodeWidth-1:0] ancestor_node;
    logic                 ancestor_exists;
  } res_t;

endpackage

// File: design/kab_table.sv
`timescale 1ns / 1ps

module kab_table import kab_pkg::*; #(
  parameter int ADDR_WIDTH = 11,
  parameter int DEPTH      = 2048
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_WIDTH-1:0] waddr_i,
  input  entry_t                wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_WIDTH-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/kab_ctrl.sv
`timescale 1ns / 1ps

module kab_ctrl import kab_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int LEVELS     = LevelsDef,
  parameter int ADDR_WIDTH = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cmd_t                  cmd_i,
  output logic                  idle_o,
  input  logic                  out_free_i,
  output logic                  done_o,
  output res_t                  res_o,
  output logic                  mem_we_o,
  output logic [ADDR_WIDTH-1:0] mem_waddr_o,
  output entry_t                mem_wdata_o,
  output logic                  mem_re_o,
  output logic [ADDR_WIDTH-1:0] mem_raddr_o,
  input  entry_t                mem_rdata_i
);

  localparam int NodeIdxW = $clog2(NODE_COUNT);
  localparam int LevelW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [StepsWidth-1:0] KMask =
    (LEVELS >= StepsWidth) ? '1 : StepsWidth'((1 << LEVELS) - 1);

  typedef enum logic [2:0] {
    StIdle,
    StBuildRd1,
    StBuildRd2,
    StBuildWr,
    StQueryStep,
    StQueryWait,
    StDone
  } state_e;

  state_e                state_q;
  logic [LevelW-1:0]     lvl_q;
  logic [NodeIdxW-1:0]   bnode_q;
  logic [NodeWidth-1:0]  cur_q;
  logic [StepsWidth-1:0] k_q;
  logic                  mid_valid_q;
  res_t                  res_q;

  logic                  node_ok;
  logic                  par_ok;
  logic [LevelW-1:0]     lvl_prev;

  assign node_ok  = int'(cmd_i.node) < NODE_COUNT;
  assign par_ok   = cmd_i.parent_exists && (int'(cmd_i.parent_node) < NODE_COUNT);
  assign lvl_prev = lvl_q - LevelW'(1);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i && (cmd_i.operation == OpSetParent) && node_ok) begin
          mem_we_o          = 1'b1;
          mem_waddr_o       = {LevelW'(0), NodeIdxW'(cmd_i.node)};
          mem_wdata_o.valid = par_ok;
          mem_wdata_o.node  = par_ok ? cmd_i.parent_node : '0;
        end
      end
      StBuildRd1: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = {lvl_prev, bnode_q};
      end
      StBuildRd2: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = {lvl_prev, NodeIdxW'(mem_rdata_i.node)};
      end
      StBuildWr: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {lvl_q, bnode_q};
        mem_wdata_o = mid_valid_q ? mem_rdata_i : '0;
      end
      StQueryStep: begin
        if ((k_q != '0) && k_q[0]) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = {lvl_q, NodeIdxW'(cur_q)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lvl_q       <= '0;
      bnode_q     <= '0;
      cur_q       <= '0;
      k_q         <= '0;
      mid_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            res_q   <= '0;
            state_q <= StDone;
            case (cmd_i.operation)
              OpBuild: begin
                if (LEVELS > 1) begin
                  lvl_q   <= LevelW'(1);
                  bnode_q <= '0;
                  state_q <= StBuildRd1;
                end
              end
              OpQuery: begin
                if (node_ok && ((cmd_i.steps_up & ~KMask) == '0)) begin
                  cur_q   <= cmd_i.node;
                  k_q     <= cmd_i.steps_up;
                  lvl_q   <= '0;
                  state_q <= StQueryStep;
                end
              end
              default: begin
              end
            endcase
          end
        end
        StBuildRd1: begin
          state_q <= StBuildRd2;
        end
        StBuildRd2: begin
          mid_valid_q <= mem_rdata_i.valid;
          state_q     <= StBuildWr;
        end
        StBuildWr: begin
          state_q <= StBuildRd1;
          if (bnode_q == NodeIdxW'(NODE_COUNT - 1)) begin
            bnode_q <= '0;
            if (lvl_q == LevelW'(LEVELS - 1)) begin
              state_q <= StDone;
            end else begin
              lvl_q <= lvl_q + LevelW'(1);
            end
          end else begin
            bnode_q <= bnode_q + NodeIdxW'(1);
          end
        end
        StQueryStep: begin
          if (k_q == '0) begin
            res_q.ancestor_node   <= cur_q;
            res_q.ancestor_exists <= 1'b1;
            state_q               <= StDone;
          end else if (k_q[0]) begin
            state_q <= StQueryWait;
          end else begin
            k_q   <= k_q >> 1;
            lvl_q <= lvl_q + LevelW'(1);
          end
        end
        StQueryWait: begin
          if (mem_rdata_i.valid) begin
            cur_q   <= mem_rdata_i.node;
            k_q     <= k_q >> 1;
            lvl_q   <= lvl_q + LevelW'(1);
            state_q <= StQueryStep;
          end else begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign idle_o = (state_q == StIdle);
  assign done_o = (state_q == StDone) && out_free_i;
  assign res_o  = res_q;

endmodule

// File: design/kth_ancestor_binary_lifting_core.sv
`timescale 1ns / 1ps

// Set parent and unused codes go straight to the result. Query: steps through each bit position
// of k up to its highest set bit and waits for a table read at each set bit. Build: each entry
// over levels 1 to LEVELS-1 takes two reads through the single read port and then a write.
// A new transaction is accepted only once the previous result has entered the output register.
// Reset clears the sequencer and the output valid; the ancestor table is not cleared.
module kth_ancestor_binary_lifting_core import kab_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int LEVELS     = LevelsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [NodeWidth-1:0]  node_i,
  input  logic [NodeWidth-1:0]  parent_node_i,
  input  logic                  parent_exists_i,
  input  logic [StepsWidth-1:0] steps_up_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [NodeWidth-1:0]  ancestor_node_o,
  output logic                  ancestor_exists_o
);

  localparam int NodeIdxW = $clog2(NODE_COUNT);
  localparam int LevelW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AddrW    = LevelW + NodeIdxW;
  localparam int Depth    = LEVELS * (2 ** NodeIdxW);

  cmd_t              cmd;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic              start;
  logic              idle;
  logic              done;
  logic              out_free;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  entry_t            mem_rdata;

  assign cmd.operation     = operation_i;
  assign cmd.node          = node_i;
  assign cmd.parent_node   = parent_node_i;
  assign cmd.parent_exists = parent_exists_i;
  assign cmd.steps_up      = steps_up_i;

  assign in_ready_o = idle;
  assign start      = in_valid_i && idle;
  assign out_free   = !out_valid_q || out_ready_i;

  kab_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .LEVELS     (LEVELS),
    .ADDR_WIDTH (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .idle_o      (idle),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  kab_table #(
    .ADDR_WIDTH (AddrW),
    .DEPTH      (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (done) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ancestor_node_o   = out_q.ancestor_node;
  assign ancestor_exists_o = out_q.ancestor_exists;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block accepted a transaction while still busy");

  a_done_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken result");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ancestor_exists_o |-> ancestor_node_o == '0)
    else $error("missing ancestor reported with nonzero node");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("two results for one transaction");

endmodule

// File: test/ancestor_check.sv
`timescale 1ns / 1ps

module ancestor_check import kab_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int LEVELS     = LevelsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            operation_i,
  input  logic [NodeWidth-1:0]  node_i,
  input  logic [NodeWidth-1:0]  parent_node_i,
  input  logic                  parent_exists_i,
  input  logic [StepsWidth-1:0] steps_up_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [NodeWidth-1:0]  ancestor_node_i,
  input  logic                  ancestor_exists_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    found_count_o
);

  entry_t lift_table [LEVELS][NODE_COUNT];
  res_t   answer_queue [$];
  int     fail_count = 0;
  int     pending_count = 0;
  int     found_count = 0;

  assign fail_count_o  = fail_count;
  assign pending_o     = pending_count;
  assign found_count_o = found_count;

  function automatic void store_parent(input logic [NodeWidth-1:0] nd,
                                       input logic [NodeWidth-1:0] par,
                                       input logic has);
    entry_t e;
    e = '0;
    if (int'(nd) < NODE_COUNT) begin
      if (has && int'(par) < NODE_COUNT) begin
        e.valid = 1'b1;
        e.node  = par;
      end
      lift_table[0][nd] = e;
    end
  endfunction

  function automatic void build_levels();
    entry_t mid;
    entry_t up;
    for (int lv = 1; lv < LEVELS; lv++) begin
      for (int n = 0; n < NODE_COUNT; n++) begin
        mid = lift_table[lv-1][n];
        up  = '0;
        if (mid.valid) begin
          up = lift_table[lv-1][mid.node];
        end
        lift_table[lv][n] = up;
      end
    end
  endfunction

  function automatic res_t climb(input logic [NodeWidth-1:0] start,
                                 input logic [StepsWidth-1:0] k);
    entry_t                e;
    logic [NodeWidth-1:0]  cur;
    logic                  ok;
    res_t                  r;
    cur = start;
    ok  = (int'(start) < NODE_COUNT);
    for (int i = 0; i < StepsWidth; i++) begin
      if (ok && k[i]) begin
        if (i >= LEVELS) begin
          ok = 1'b0;
        end else begin
          e = lift_table[i][cur];
          if (!e.valid) begin
            ok = 1'b0;
          end else begin
            cur = e.node;
          end
        end
      end
    end
    r.ancestor_node   = ok ? cur : '0;
    r.ancestor_exists = ok;
    return r;
  endfunction

  function automatic void note_failure(input string what, input res_t want, input res_t got);
    if (fail_count < 10) begin
      $display("%s: expected node %0d exists %0b, got node %0d exists %0b",
               what, want.ancestor_node, want.ancestor_exists,
               got.ancestor_node, got.ancestor_exists);
    end
    fail_count++;
  endfunction

  always @(posedge clk_i) begin : monitor
    res_t predicted;
    res_t oldest;
    res_t observed;
    op_e  op;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        op = op_e'(operation_i);
        predicted = '0;
        case (op)
          OpSetParent: begin
            store_parent(node_i, parent_node_i, parent_exists_i);
          end
          OpBuild: begin
            build_levels();
          end
          OpQuery: begin
            predicted = climb(node_i, steps_up_i);
            if (predicted.ancestor_exists) found_count++;
          end
          default: begin
          end
        endcase
        answer_queue.insert(answer_queue.size(), predicted);
      end
      if (out_valid_i && out_ready_i) begin
        observed.ancestor_node   = ancestor_node_i;
        observed.ancestor_exists = ancestor_exists_i;
        if (answer_queue.size() == 0) begin
          note_failure("unexpected transaction", '0, observed);
        end else begin
          oldest = answer_queue.pop_front();
          if (oldest.ancestor_node !== observed.ancestor_node) begin
            note_failure("ancestor_node mismatch", oldest, observed);
          end else if (oldest.ancestor_exists !== observed.ancestor_exists) begin
            note_failure("ancestor_exists mismatch", oldest, observed);
          end
        end
      end
      pending_count = answer_queue.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kab_pkg::*;

  localparam int NodeCount   = NodeCountDef;
  localparam int Levels      = LevelsDef;
  localparam int RandomItems = 1170;
  localparam int CycleLimit  = 1000000;
  localparam int HoldAt      = 900;
  localparam int HoldCycles  = 300;
  localparam int PauseAt     = 1100;
  localparam int SecondRoot  = 170;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            operation = '0;
  logic [NodeWidth-1:0]  node = '0;
  logic [NodeWidth-1:0]  parent_node = '0;
  logic                  parent_exists = 1'b0;
  logic [StepsWidth-1:0] steps_up = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [NodeWidth-1:0]  ancestor_node;
  logic                  ancestor_exists;

  int fail_count;
  int pending;
  int found_count;
  int cycle_count = 0;
  int set_count = 0;
  int build_count = 0;
  int query_count = 0;
  bit tx_burst = 1'b0;

  always #4 clk_i = ~clk_i;

  kth_ancestor_binary_lifting_core #(
    .NODE_COUNT(NodeCount),
    .LEVELS    (Levels)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .node_i           (node),
    .parent_node_i    (parent_node),
    .parent_exists_i  (parent_exists),
    .steps_up_i       (steps_up),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .ancestor_node_o  (ancestor_node),
    .ancestor_exists_o(ancestor_exists)
  );

  ancestor_check #(
    .NODE_COUNT(NodeCount),
    .LEVELS    (Levels)
  ) u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .node_i           (node),
    .parent_node_i    (parent_node),
    .parent_exists_i  (parent_exists),
    .steps_up_i       (steps_up),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .ancestor_node_i  (ancestor_node),
    .ancestor_exists_i(ancestor_exists),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .found_count_o    (found_count)
  );

  task automatic send_cmd(input op_e op, input logic [NodeWidth-1:0] nd,
                          input logic [NodeWidth-1:0] par, input logic has,
                          input logic [StepsWidth-1:0] k);
    int gap;
    gap = tx_burst ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    node          <= nd;
    parent_node   <= par;
    parent_exists <= has;
    steps_up      <= k;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    case (op)
      OpSetParent: set_count++;
      OpBuild:     build_count++;
      default:     query_count++;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic random_cmd();
    int                    roll;
    int                    kind;
    logic [NodeWidth-1:0]  nd;
    logic [NodeWidth-1:0]  par;
    logic [StepsWidth-1:0] k;
    roll = int'($urandom_range(0, 99));
    if (roll < 1) begin
      send_cmd(OpBuild, NodeWidth'($urandom), NodeWidth'($urandom), 1'($urandom),
               StepsWidth'($urandom));
    end else if (roll < 38) begin
      nd   = NodeWidth'($urandom);
      kind = int'($urandom_range(0, 19));
      if (kind == 0) begin
        send_cmd(OpSetParent, nd, NodeWidth'($urandom), 1'b0, StepsWidth'($urandom));
      end else if (kind < 3) begin
        send_cmd(OpSetParent, nd, NodeWidth'($urandom), 1'b1, StepsWidth'($urandom));
      end else begin
        par = nd - NodeWidth'($urandom_range(1, 4));
        send_cmd(OpSetParent, nd, par, 1'b1, StepsWidth'($urandom));
      end
    end else begin
      nd = NodeWidth'(($urandom_range(0, 4) < 3) ? $urandom_range(128, 255)
                                                 : $urandom_range(0, 255));
      k  = StepsWidth'($urandom_range(0, 1) ? $urandom_range(0, 140)
                                            : $urandom_range(0, 255));
      send_cmd(OpQuery, nd, NodeWidth'($urandom), 1'($urandom), k);
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    int taken;
    bit rx_burst;
    taken    = 0;
    rx_burst = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken == HoldAt) begin
        wait_cycles = HoldCycles;
      end else begin
        wait_cycles = rx_burst ? 0 : int'($urandom_range(0, 7));
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      @(negedge clk_i);
      taken++;
    end
  end

  initial begin : stimulus
    int back;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every node gets a level 0 entry before anything reads the table.
    for (int n = 0; n < NodeCount; n++) begin
      if (n == 0 || n == SecondRoot) begin
        send_cmd(OpSetParent, NodeWidth'(n), NodeWidth'($urandom), 1'b0,
                 StepsWidth'($urandom));
      end else begin
        back = (n >= 3) ? int'($urandom_range(1, 3)) : 1;
        send_cmd(OpSetParent, NodeWidth'(n), NodeWidth'(n - back), 1'b1,
                 StepsWidth'($urandom));
      end
    end

    send_cmd(OpQuery, 8'd7, 8'd0, 1'b0, 8'd0);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd1);
    send_cmd(OpBuild, 8'd0, 8'd0, 1'b0, 8'd0);
    send_cmd(OpQuery, 8'd0, 8'd0, 1'b0, 8'd0);
    send_cmd(OpQuery, 8'd0, 8'd0, 1'b0, 8'd1);
    send_cmd(OpQuery, 8'd0, 8'hff, 1'b1, 8'd255);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd255);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd128);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'b0101_0101);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'b1010_1010);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd40);
    send_cmd(OpQuery, 8'(SecondRoot), 8'd0, 1'b0, 8'd1);
    send_cmd(OpQuery, 8'(SecondRoot + 1), 8'd0, 1'b0, 8'd1);
    send_cmd(OpQuery, 8'd128, 8'd0, 1'b0, 8'd127);
    send_cmd(OpSetParent, 8'd255, 8'd0, 1'b1, 8'd0);
    send_cmd(OpSetParent, 8'd0, 8'd255, 1'b0, 8'd0);
    send_cmd(OpSetParent, 8'd254, 8'd255, 1'b1, 8'd0);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd1);
    send_cmd(OpQuery, 8'd254, 8'd0, 1'b0, 8'd3);
    send_cmd(OpBuild, 8'hff, 8'hff, 1'b1, 8'hff);
    send_cmd(OpQuery, 8'd254, 8'd0, 1'b0, 8'd3);
    send_cmd(OpQuery, 8'd255, 8'd0, 1'b0, 8'd2);
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (i == PauseAt) drain_results();
      random_cmd();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("covered %0d transactions: %0d parent writes, %0d level builds, %0d queries",
             set_count + build_count + query_count, set_count, build_count, query_count);
    $display("%0d queries found an ancestor; the result side held off once for %0d cycles",
             found_count, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
